>>> rtl/core/slpq_pkg.sv
// Package for the sorted-list priority queue: widths, codes and shared types.
// No dependencies.
package slpq_pkg;
    localparam int Capacity = 16;
    localparam int IdxW     = $clog2(Capacity + 1);
    localparam int CntW     = $clog2(Capacity + 1);
    localparam int QDepth   = 2;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_TOP  = 2'd2,
        REQ_FIND = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOTF  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ORD_LE = 2'd0,
        ORD_LT = 2'd1,
        ORD_GE = 2'd2,
        ORD_GT = 2'd3
    } t_order;

    typedef struct packed {
        logic [1:0]   req_type;
        logic [31:0]  elem;
        logic [31:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0]   status;
        logic [31:0]  out_elem;
        logic [31:0]  out_priority;
        logic         is_empty;
        logic [4:0]   occupancy;
    } t_out_item;

    // New priority p goes before stored q under the given relation.
    function automatic logic comes_before(input logic [1:0] mode,
                                          input logic signed [31:0] p,
                                          input logic signed [31:0] q);
        logic r;
        case (mode)
            ORD_LE:  r = (p <= q);
            ORD_LT:  r = (p < q);
            ORD_GE:  r = (p >= q);
            default: r = (p > q);
        endcase
        return r;
    endfunction
endpackage

>>> rtl/core/slpq_if.sv
// Valid/ready channel interfaces for the priority queue.
// Depends on slpq_pkg.
interface slpq_in_if;
    import slpq_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slpq_out_if;
    import slpq_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slpq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/slpq_front.sv
// Front end: accepts request transactions into a short queue.
// Depends on slpq_pkg and slpq_if.
module slpq_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slpq_in_if.sink               i_req,
    input  logic                  i_take,
    output logic                  o_avail,
    output slpq_pkg::t_in_item    o_item
);
    import slpq_pkg::*;

    localparam int PW = $clog2(QDepth);

    t_in_item        r_mem [QDepth];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push_en, pop_en;

    assign i_req.ready = (r_cnt != (PW+1)'(QDepth));
    assign push_en     = i_req.valid && i_req.ready;
    assign o_avail     = (r_cnt != '0);
    assign pop_en      = i_take && o_avail;
    assign o_item      = r_mem[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wp] <= i_req.data;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_en) r_wp <= r_wp + 1'b1;
            if (pop_en)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push_en) - (PW+1)'(pop_en);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QDepth)) else $error("queue overfilled");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop_en) else $error("queue underflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (PW+1)'(QDepth)) |-> !push_en) else $error("push when full");
endmodule

>>> rtl/core/slpq_back.sv
// Back end: walks the node store and performs push, pop, top and lookup.
// Depends on slpq_pkg and slpq_if.
module slpq_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_order,
    input  logic                  i_avail,
    input  slpq_pkg::t_in_item    i_item,
    output logic                  o_take,
    output logic                  o_idle,
    slpq_out_if.source            o_res
);
    import slpq_pkg::*;

    localparam logic [IdxW-1:0] NIL = IdxW'(Capacity);
    localparam int AW = $clog2(Capacity);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [31:0]       r_elem_mem [Capacity];
    logic [31:0]       r_prio_mem [Capacity];
    logic [IdxW-1:0]   r_link [Capacity];
    logic [IdxW-1:0]   r_head, r_tail, r_free;
    logic [CntW-1:0]   r_count, r_steps;
    t_in_item          r_item;
    logic [IdxW-1:0]   r_cur, r_prev, r_node;
    logic              r_ovalid;
    t_out_item         r_out;
    t_out_item         r_res;
    logic [31:0]       rd_elem, rd_prio;
    logic              cur_ok, hit, full;
    logic [AW-1:0]     cur_a;

    assign cur_a   = r_cur[AW-1:0];
    assign cur_ok  = (r_cur < NIL) && (r_steps < CntW'(Capacity));
    assign full    = (r_count >= CntW'(Capacity)) || (r_free >= NIL);
    assign rd_elem = r_elem_mem[cur_a];
    assign rd_prio = r_prio_mem[cur_a];
    assign hit     = (r_item.req_type == REQ_PUSH)
                   ? comes_before(i_order, r_item.priority_req, rd_prio)
                   : (rd_elem == r_item.elem);

    assign o_take       = (r_state == S_IDLE) && i_avail;
    assign o_idle       = (r_state == S_IDLE) && !r_ovalid && !i_avail;
    assign o_res.valid  = r_ovalid;
    assign o_res.data   = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_avail) n_state = S_WALK;
            S_WALK:  if (r_item.req_type == REQ_POP || r_item.req_type == REQ_TOP
                         || (r_item.req_type == REQ_PUSH && full)
                         || !cur_ok || hit
                         || (r_item.req_type == REQ_FIND && r_steps >= r_count))
                         n_state = S_DONE;
            S_DONE:  n_state = S_OUT;
            S_OUT:   if (!r_ovalid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, list pointers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_free   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < Capacity; i++) r_link[i] <= IdxW'(i + 1);
        end else begin
            r_state <= n_state;
            if (o_res.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_avail) begin
                    r_item  <= i_item;
                    r_cur   <= r_head;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_out   <= '0;
                end
                S_WALK: begin
                    case (r_item.req_type)
                        REQ_PUSH: begin
                            if (full) begin
                                r_out.status <= ST_FULL;
                            end else if (!cur_ok || hit) begin
                                r_out.status <= ST_OK;
                                r_node <= r_free;
                                if (!cur_ok) r_cur <= NIL;
                            end else begin
                                r_prev  <= r_cur;
                                r_cur   <= r_link[cur_a];
                                r_steps <= r_steps + 1'b1;
                            end
                        end
                        REQ_FIND: begin
                            if (!cur_ok || r_steps >= r_count) begin
                                r_out.status       <= ST_NOTF;
                                r_out.out_priority <= '1;
                            end else if (hit) begin
                                r_out.status       <= ST_OK;
                                r_out.out_priority <= rd_prio;
                            end else begin
                                r_cur   <= r_link[cur_a];
                                r_steps <= r_steps + 1'b1;
                            end
                        end
                        default: begin
                            if (r_count == '0 || r_head >= NIL) begin
                                r_out.status <= ST_EMPTY;
                            end else begin
                                r_out.status       <= ST_OK;
                                r_out.out_elem     <= r_elem_mem[r_head[AW-1:0]];
                                r_out.out_priority <= r_prio_mem[r_head[AW-1:0]];
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    if (r_item.req_type == REQ_PUSH && r_out.status == ST_OK) begin
                        r_free <= r_link[r_node[AW-1:0]];
                        r_link[r_node[AW-1:0]] <= r_cur;
                        if (r_prev >= NIL) r_head <= r_node;
                        else r_link[r_prev[AW-1:0]] <= r_node;
                        if (r_cur == NIL) r_tail <= r_node;
                        r_count <= r_count + 1'b1;
                    end else if (r_item.req_type == REQ_POP
                                 && r_out.status == ST_OK) begin
                        r_link[r_head[AW-1:0]] <= r_free;
                        r_free  <= r_head;
                        r_count <= r_count - 1'b1;
                        if (r_count == CntW'(1)) begin
                            r_head <= NIL;
                            r_tail <= NIL;
                        end else begin
                            r_head <= r_link[r_head[AW-1:0]];
                        end
                    end
                end
                S_OUT: if (!r_ovalid || o_res.ready) begin
                    r_ovalid           <= 1'b1;
                    r_res              <= r_out;
                    r_res.is_empty     <= (r_count == '0);
                    r_res.occupancy    <= 5'(r_count);
                end
                default: ;
            endcase
        end
    end

    // element and priority stores, written on a successful push
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && r_item.req_type == REQ_PUSH
            && r_out.status == ST_OK) begin
            r_elem_mem[r_node[AW-1:0]] <= r_item.elem;
            r_prio_mem[r_node[AW-1:0]] <= r_item.priority_req;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Capacity)) else $error("count too large");
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == NIL)) else $error("empty list has head");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_res.ready) |=> $stable(r_res)) else $error("result changed");
endmodule

>>> rtl/core/sorted_list_priority_queue.sv
// Top level of the sorted-list priority queue: front queue, back walker, config.
// Depends on slpq_pkg, slpq_if, slpq_front and slpq_back.
//
//  channel  dir  payload                                          handshake
//  i_req    in   req_type, elem, priority_req                     valid/ready
//  o_res    out  status, out_elem, out_priority, is_empty, occ.   valid/ready
//  i_cfg    in   order_mode                                       valid/ready
//
// Pop and top read only the list head; push and lookup walk the list one node
// per cycle in the back end, visiting at most Capacity nodes.
// Reset is synchronous and restores an empty list with the free chain in order.
// A two-entry request queue keeps accepting while a result waits on o_res.
module sorted_list_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slpq_in_if.sink    i_req,
    slpq_out_if.source o_res,
    slpq_cfg_if.sink   i_cfg
);
    import slpq_pkg::*;

    logic [1:0] r_mode;
    logic       avail, take, idle;
    t_in_item   item;

    assign i_cfg.ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ORD_LE;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.data;
        end
    end

    slpq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_avail (avail),
        .o_item  (item)
    );

    slpq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_order (r_mode),
        .i_avail (avail),
        .i_item  (item),
        .o_take  (take),
        .o_idle  (idle),
        .o_res   (o_res)
    );

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |-> idle) else $error("config while busy");
endmodule
